// ----- src/irpw_pkg.sv -----
package irpw_pkg;

  // message framing
  localparam int MSG_BITS     = 14;
  localparam int MAX_BYTES    = 4;
  localparam int BIT_CAP      = MAX_BYTES * 8;
  localparam int CNT_W        = $clog2(BIT_CAP + 1);
  localparam int GLITCH_TICKS = 15;

  localparam int TIME_W = 32;
  localparam int WIN_W  = 16;
  localparam int IDX_W  = 3;

  // output tdata layout, lowest field first
  localparam int OUT_DATA_W = 40;

  typedef enum logic [IDX_W-1:0] {
    REG_HEADER_MIN = 3'd0,
    REG_HEADER_MAX = 3'd1,
    REG_SPACE_MIN  = 3'd2,
    REG_SPACE_MAX  = 3'd3,
    REG_ONE_MIN    = 3'd4,
    REG_ONE_MAX    = 3'd5,
    REG_ZERO_MIN   = 3'd6,
    REG_ZERO_MAX   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [WIN_W-1:0] header_min;
    logic [WIN_W-1:0] header_max;
    logic [WIN_W-1:0] space_min;
    logic [WIN_W-1:0] space_max;
    logic [WIN_W-1:0] one_min;
    logic [WIN_W-1:0] one_max;
    logic [WIN_W-1:0] zero_min;
    logic [WIN_W-1:0] zero_max;
  } win_cfg_t;

  typedef struct packed {
    logic                is_shot;
    logic [MSG_BITS-1:0] raw_bits;
    logic [6:0]          player_id;
    logic [1:0]          team_id;
    logic [3:0]          damage_code;
    logic [6:0]          damage_value;
  } msg_res_t;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_SPACE  = 4'b0100,
    PH_BIT    = 4'b1000
  } phase_t;

  // strict window check, both bounds exclusive
  function automatic logic win_hit(input logic [TIME_W-1:0] v,
                                   input logic [WIN_W-1:0] lo,
                                   input logic [WIN_W-1:0] hi);
    logic [TIME_W-1:0] lo_x;
    logic [TIME_W-1:0] hi_x;
    lo_x = {{(TIME_W-WIN_W){1'b0}}, lo};
    hi_x = {{(TIME_W-WIN_W){1'b0}}, hi};
    return (v > lo_x) && (v < hi_x);
  endfunction

  function automatic logic [6:0] damage_lookup(input logic [3:0] code);
    logic [6:0] val;
    unique case (code)
      4'd0:    val = 7'd1;
      4'd1:    val = 7'd2;
      4'd2:    val = 7'd4;
      4'd3:    val = 7'd5;
      4'd4:    val = 7'd7;
      4'd5:    val = 7'd10;
      4'd6:    val = 7'd15;
      4'd7:    val = 7'd17;
      4'd8:    val = 7'd20;
      4'd9:    val = 7'd25;
      4'd10:   val = 7'd30;
      4'd11:   val = 7'd35;
      4'd12:   val = 7'd40;
      4'd13:   val = 7'd50;
      4'd14:   val = 7'd75;
      4'd15:   val = 7'd100;
      default: val = 7'd1;
    endcase
    return val;
  endfunction

endpackage

// ----- src/irpw_cfg_regs.sv -----
module irpw_cfg_regs
  import irpw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  reg_idx_t         wr_idx,
  input  logic [WIN_W-1:0] wr_data,
  output win_cfg_t         cfg
);

  win_cfg_t cfg_r;
  win_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        REG_HEADER_MIN: cfg_nxt.header_min = wr_data;
        REG_HEADER_MAX: cfg_nxt.header_max = wr_data;
        REG_SPACE_MIN:  cfg_nxt.space_min  = wr_data;
        REG_SPACE_MAX:  cfg_nxt.space_max  = wr_data;
        REG_ONE_MIN:    cfg_nxt.one_min    = wr_data;
        REG_ONE_MAX:    cfg_nxt.one_max    = wr_data;
        REG_ZERO_MIN:   cfg_nxt.zero_min   = wr_data;
        REG_ZERO_MAX:   cfg_nxt.zero_max   = wr_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_min <= 16'd2000;
      cfg_r.header_max <= 16'd2800;
      cfg_r.space_min  <= 16'd400;
      cfg_r.space_max  <= 16'd800;
      cfg_r.one_min    <= 16'd1000;
      cfg_r.one_max    <= 16'd1400;
      cfg_r.zero_min   <= 16'd400;
      cfg_r.zero_max   <= 16'd800;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/irpw_core.sv -----
module irpw_core
  import irpw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              level,
  input  logic [TIME_W-1:0] edge_time,
  input  win_cfg_t          cfg,
  output logic              res_valid,
  output msg_res_t          res
);

  phase_t              phase_r, phase_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic                glitch_r, glitch_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [MSG_BITS-1:0] store_r, store_nxt;

  logic [TIME_W-1:0] gap;
  logic              hdr_ok, space_ok, one_ok, zero_ok;
  logic [3:0]        bit_idx;

  assign gap      = edge_time - last_r;
  assign hdr_ok   = win_hit(gap, cfg.header_min, cfg.header_max);
  assign space_ok = win_hit(gap, cfg.space_min, cfg.space_max);
  assign one_ok   = win_hit(gap, cfg.one_min, cfg.one_max);
  assign zero_ok  = win_hit(gap, cfg.zero_min, cfg.zero_max);
  assign bit_idx  = 4'(MSG_BITS - 1) - count_r[3:0];

  always_comb begin
    phase_nxt  = phase_r;
    last_nxt   = last_r;
    glitch_nxt = glitch_r;
    count_nxt  = count_r;
    store_nxt  = store_r;
    res_valid  = 1'b0;
    if (step) begin
      if (gap < TIME_W'(GLITCH_TICKS)) begin
        glitch_nxt = 1'b1;
      end else if (glitch_r) begin
        glitch_nxt = 1'b0;
      end else begin
        last_nxt = edge_time;
        unique case (phase_r)
          PH_WAIT: begin
            if (level) begin
              phase_nxt = PH_HEADER;
            end else begin
              count_nxt = '0;
            end
          end
          PH_HEADER: begin
            if (!level && hdr_ok) begin
              phase_nxt = PH_SPACE;
            end else begin
              phase_nxt = PH_WAIT;
              count_nxt = '0;
            end
          end
          PH_SPACE: begin
            if (level && space_ok) begin
              phase_nxt = PH_BIT;
            end else begin
              phase_nxt = PH_WAIT;
              count_nxt = '0;
            end
          end
          PH_BIT: begin
            if (!level && (one_ok || zero_ok)) begin
              phase_nxt = PH_SPACE;
              // bits past the cap keep timing but are dropped
              if (count_r < CNT_W'(BIT_CAP)) begin
                count_nxt = count_r + 1'b1;
                if (count_r < CNT_W'(MSG_BITS)) begin
                  store_nxt[bit_idx] = one_ok;
                end
              end
              if (count_r == CNT_W'(MSG_BITS - 1)) begin
                res_valid = 1'b1;
                // shot message ends the frame
                if (!store_nxt[MSG_BITS-1]) begin
                  phase_nxt = PH_WAIT;
                  count_nxt = '0;
                end
              end
            end else begin
              phase_nxt = PH_WAIT;
              count_nxt = '0;
            end
          end
          default: begin
            phase_nxt = PH_WAIT;
            count_nxt = '0;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.is_shot      = ~store_nxt[13];
    res.raw_bits     = store_nxt;
    res.player_id    = store_nxt[12:6];
    res.team_id      = store_nxt[5:4];
    res.damage_code  = store_nxt[3:0];
    res.damage_value = damage_lookup(store_nxt[3:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      last_r   <= '0;
      glitch_r <= 1'b0;
      count_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      last_r   <= last_nxt;
      glitch_r <= glitch_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

endmodule

// ----- src/ir_pulse_width_message_decoder.sv -----
// infrared pulse-width message decoder
//
// in_*  : one item per line edge; in_tuser is the level after the edge,
//         in_tdata the free-running 32-bit timer value at that edge
// out_* : one item per completed 14-bit message (raw bits, shot flag,
//         player, team, damage code and decoded damage value)
// cfg_* : writes the eight strict timing windows; cfg_ready is always high,
//         writes are meant for idle periods only
//
// an accepted item lands in an input register; once it may move on, the
// frame logic checks it against the state and the result register takes
// the message if one completed, so out_tvalid rises once its edge has
// passed both registers. one edge is taken every cycle as long as the
// result register is empty or being drained.
// when the receiver stalls with a result waiting, the input register
// holds its edge and in_tready drops; nothing is lost or repeated.
// reset restores the default windows, empties both registers and puts
// the receiver back to waiting for a header with no glitch pending
module ir_pulse_width_message_decoder
  import irpw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input edges
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TIME_W-1:0]     in_tdata,   // [31:0] edge_time
  input  logic                  in_tuser,   // [0] edge_level
  // decoded messages
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [13:0] raw_bits, [20:14] player_id, [22:21] team_id,
  // [26:23] damage_code, [33:27] damage_value, [39:34] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // [0] is_shot
  // window register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [WIN_W-1:0]      cfg_data
);

  win_cfg_t cfg;

  // input register
  logic              in_vld_r, in_vld_nxt;
  logic              in_lvl_r;
  logic [TIME_W-1:0] in_time_r;

  // result register
  logic     out_vld_r, out_vld_nxt;
  msg_res_t out_res_r;

  logic     advance;
  logic     res_valid;
  msg_res_t res;

  assign cfg_ready = 1'b1;

  irpw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (reg_idx_t'(cfg_index)),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // the held edge moves on when the result slot is free or draining
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  irpw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .level     (in_lvl_r),
    .edge_time (in_time_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tready) begin
      in_vld_nxt = in_tvalid;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = res_valid;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_lvl_r  <= in_tuser;
      in_time_r <= in_tdata;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.is_shot;
  assign out_tdata  = {6'd0,
                       out_res_r.damage_value,
                       out_res_r.damage_code,
                       out_res_r.team_id,
                       out_res_r.player_id,
                       out_res_r.raw_bits};

endmodule

// ----- tb/ir_pulse_width_checker.sv -----
`timescale 1ns / 1ps

module ir_pulse_width_checker
  import irpw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [TIME_W-1:0]     in_tdata,   // [31:0] edge_time
  input  logic                  in_tuser,   // [0] edge_level
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [13:0] raw_bits, [20:14] player_id, [22:21] team_id,
  // [26:23] damage_code, [33:27] damage_value, [39:34] zero
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,  // [0] is_shot
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [WIN_W-1:0]      cfg_data,
  output int                    fail_cnt,
  output int                    pending_cnt,
  output int                    predicted_cnt,
  output int                    checked_cnt
);

  // damage points per code, one byte each, code 0 in the low byte
  localparam logic [127:0] DMG_PTS = {8'd100, 8'd75, 8'd50, 8'd40, 8'd35, 8'd30, 8'd25,
                                      8'd20, 8'd17, 8'd15, 8'd10, 8'd7, 8'd5, 8'd4,
                                      8'd2, 8'd1};

  win_cfg_t           win;
  phase_t             rx_phase;
  logic [TIME_W-1:0]  last_time;
  logic               glitch_pend;
  int                 bit_cnt;
  logic [BIT_CAP-1:0] msg_bits;      // first received bit at the top
  msg_res_t           pending_msgs[$];

  function automatic logic gap_in(input logic [TIME_W-1:0] gap,
                                  input logic [WIN_W-1:0] lo,
                                  input logic [WIN_W-1:0] hi);
    return (gap > 32'(lo)) && (gap < 32'(hi));
  endfunction

  task automatic rx_restart();
    rx_phase    = PH_WAIT;
    bit_cnt     = 0;
    glitch_pend = 1'b0;
  endtask

  task automatic decode_edge(input logic lvl, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] gap;
    logic              got_bit;
    logic              bit_val;
    logic [7:0]        b0;
    logic [7:0]        b1;
    int                code;
    msg_res_t          m;
    gap     = now - last_time;
    got_bit = 1'b0;
    bit_val = 1'b0;
    if (gap < GLITCH_TICKS) begin
      glitch_pend = 1'b1;
    end else if (glitch_pend) begin
      glitch_pend = 1'b0;
    end else begin
      last_time = now;
      case (rx_phase)
        PH_WAIT: begin
          if (lvl) rx_phase = PH_HEADER;
          else rx_restart();
        end
        PH_HEADER: begin
          if (!lvl && gap_in(gap, win.header_min, win.header_max)) rx_phase = PH_SPACE;
          else rx_restart();
        end
        PH_SPACE: begin
          if (lvl && gap_in(gap, win.space_min, win.space_max)) rx_phase = PH_BIT;
          else rx_restart();
        end
        default: begin
          // mark: a one wins where both windows fit
          if (lvl) begin
            rx_restart();
          end else if (gap_in(gap, win.one_min, win.one_max)) begin
            got_bit = 1'b1;
            bit_val = 1'b1;
          end else if (gap_in(gap, win.zero_min, win.zero_max)) begin
            got_bit = 1'b1;
          end else begin
            rx_restart();
          end
        end
      endcase
    end
    if (got_bit) begin
      rx_phase = PH_SPACE;
      if (bit_cnt < BIT_CAP) begin
        msg_bits[BIT_CAP-1-bit_cnt] = bit_val;
        bit_cnt++;
      end
      if (bit_cnt == MSG_BITS) begin
        b0             = msg_bits[BIT_CAP-1 -: 8];
        b1             = msg_bits[BIT_CAP-9 -: 8];
        code           = b1[5:2];
        m.is_shot      = ~b0[7];
        m.raw_bits     = msg_bits[BIT_CAP-1 -: MSG_BITS];
        m.player_id    = b0[6:0];
        m.team_id      = b1[7:6];
        m.damage_code  = b1[5:2];
        m.damage_value = DMG_PTS[code*8 +: 7];
        pending_msgs.push_back(m);
        predicted_cnt++;
        if (m.is_shot) rx_restart();
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor
    msg_res_t want;
    if (!rst_n) begin
      win.header_min = 16'd2000;
      win.header_max = 16'd2800;
      win.space_min  = 16'd400;
      win.space_max  = 16'd800;
      win.one_min    = 16'd1000;
      win.one_max    = 16'd1400;
      win.zero_min   = 16'd400;
      win.zero_max   = 16'd800;
      last_time      = '0;
      msg_bits       = '0;
      rx_restart();
      pending_msgs.delete();
      fail_cnt       = 0;
      predicted_cnt  = 0;
      checked_cnt    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEADER_MIN: win.header_min = cfg_data;
          REG_HEADER_MAX: win.header_max = cfg_data;
          REG_SPACE_MIN:  win.space_min  = cfg_data;
          REG_SPACE_MAX:  win.space_max  = cfg_data;
          REG_ONE_MIN:    win.one_min    = cfg_data;
          REG_ONE_MAX:    win.one_max    = cfg_data;
          REG_ZERO_MIN:   win.zero_min   = cfg_data;
          REG_ZERO_MAX:   win.zero_max   = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) decode_edge(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (pending_msgs.size() == 0) begin
          $error("message with none pending: tdata %h, tuser %b", out_tdata, out_tuser);
          fail_cnt++;
        end else begin
          want = pending_msgs.pop_front();
          checked_cnt++;
          check_field("is_shot", want.is_shot, out_tuser);
          check_field("raw_bits", want.raw_bits, out_tdata[13:0]);
          check_field("player_id", want.player_id, out_tdata[20:14]);
          check_field("team_id", want.team_id, out_tdata[22:21]);
          check_field("damage_code", want.damage_code, out_tdata[26:23]);
          check_field("damage_value", want.damage_value, out_tdata[33:27]);
          check_field("tdata padding", 0, out_tdata[39:34]);
        end
      end
    end
    pending_cnt = pending_msgs.size();
  end

endmodule

// ----- tb/tb_ir_pulse_width_message_decoder.sv -----
`timescale 1ns / 1ps

module tb_ir_pulse_width_message_decoder;
  import irpw_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // edge stream into the block
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TIME_W-1:0]     in_tdata  = '0;    // [31:0] edge_time
  logic                  in_tuser  = 1'b0;  // [0] edge_level

  // decoded messages out of the block
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [13:0] raw_bits, [20:14] player_id, [22:21] team_id,
  // [26:23] damage_code, [33:27] damage_value, [39:34] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;         // [0] is_shot

  // window register writes
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = REG_HEADER_MIN;
  logic [WIN_W-1:0]      cfg_data  = '0;

  int fail_cnt;
  int pending_cnt;
  int predicted_cnt;
  int checked_cnt;

  // stimulus-side copy of the windows, only used to shape legal frames
  logic [WIN_W-1:0]  lim [8];
  logic [TIME_W-1:0] t_now;     // timestamp of the last item sent
  bit                no_idle;   // stretch where neither side holds off
  int                edge_cnt;
  int                cfg_sets;

  always #1 clk = ~clk;

  ir_pulse_width_message_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ir_pulse_width_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_cnt      (fail_cnt),
    .pending_cnt   (pending_cnt),
    .predicted_cnt (predicted_cnt),
    .checked_cnt   (checked_cnt)
  );

  // receiver back-pressure, dropped during the no-idle stretch
  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 26);
  end

  // smallest width that both clears the window floor and escapes the glitch filter
  function automatic int unsigned gap_floor(input logic [WIN_W-1:0] lo);
    int unsigned a;
    a = 32'(lo);
    a = a + 1;
    if (a < GLITCH_TICKS) a = GLITCH_TICKS;
    return a;
  endfunction

  function automatic bit win_open(input logic [WIN_W-1:0] lo, input logic [WIN_W-1:0] hi);
    return gap_floor(lo) < hi;
  endfunction

  // width strictly inside the window; an empty window gives a width that misses it
  function automatic int unsigned pick_gap(input logic [WIN_W-1:0] lo,
                                           input logic [WIN_W-1:0] hi);
    int unsigned a;
    a = gap_floor(lo);
    if (a < hi) return $urandom_range(hi - 1, a);
    return a;
  endfunction

  function automatic logic [31:0] rand_window();
    logic [15:0] x;
    logic [15:0] y;
    x = 16'($urandom);
    y = 16'($urandom);
    return (x < y) ? {x, y} : {y, x};
  endfunction

  // one item on the edge stream; random hold-off before it unless in the no-idle stretch
  task automatic send_edge(input logic lvl, input logic [TIME_W-1:0] stamp);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= lvl;
    in_tdata  <= stamp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    t_now = stamp;
    edge_cnt++;
  endtask

  // edge a given width after the last one; sometimes a glitch pair slips in first,
  // which the block drops without moving its reference time
  task automatic edge_gap(input logic lvl, input int unsigned gap, input bit may_glitch);
    logic [TIME_W-1:0] base;
    base = t_now;
    if (may_glitch && gap > 40 && $urandom_range(99) < 5) begin
      send_edge(1'($urandom_range(1)), base + $urandom_range(GLITCH_TICKS - 1));
      send_edge(1'($urandom_range(1)), base + $urandom_range(gap - 1, GLITCH_TICKS));
    end
    send_edge(lvl, base + gap);
  endtask

  task automatic settle(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [WIN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lim[idx] = val;
  endtask

  // all eight windows, written only once the block has drained
  task automatic program_windows(input logic [WIN_W-1:0] hmin, input logic [WIN_W-1:0] hmax,
                                 input logic [WIN_W-1:0] smin, input logic [WIN_W-1:0] smax,
                                 input logic [WIN_W-1:0] omin, input logic [WIN_W-1:0] omax,
                                 input logic [WIN_W-1:0] zmin, input logic [WIN_W-1:0] zmax);
    settle(8);
    write_reg(REG_HEADER_MIN, hmin);
    write_reg(REG_HEADER_MAX, hmax);
    write_reg(REG_SPACE_MIN, smin);
    write_reg(REG_SPACE_MAX, smax);
    write_reg(REG_ONE_MIN, omin);
    write_reg(REG_ONE_MAX, omax);
    write_reg(REG_ZERO_MIN, zmin);
    write_reg(REG_ZERO_MAX, zmax);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_sets++;
  endtask

  // one frame: rising edge, header, then space/mark pairs; shots stop at 14 bits,
  // other messages sometimes run on past the bit store; now and then one edge is broken
  task automatic send_frame();
    bit          one_ok;
    bit          zero_ok;
    bit          b;
    bit          shot;
    int          nbits;
    int          bad_at;
    logic        lvl;
    int unsigned gap;
    one_ok  = win_open(lim[REG_ONE_MIN], lim[REG_ONE_MAX]);
    zero_ok = win_open(lim[REG_ZERO_MIN], lim[REG_ZERO_MAX]);
    b       = (one_ok && zero_ok) ? 1'($urandom_range(1)) : one_ok;
    shot    = !b;
    nbits   = (shot || $urandom_range(3) != 0) ? MSG_BITS : $urandom_range(40, MSG_BITS + 1);
    bad_at  = ($urandom_range(99) < 15) ? $urandom_range(2 * nbits + 1) : -1;
    for (int k = 0; k <= 2 * nbits + 1; k++) begin
      if (k == 0) begin
        // quiet line before the frame; rarely a jump anywhere on the timer
        lvl = 1'b1;
        gap = ($urandom_range(19) == 0) ? $urandom : $urandom_range(200000, 3000);
      end else if (k == 1) begin
        lvl = 1'b0;
        gap = pick_gap(lim[REG_HEADER_MIN], lim[REG_HEADER_MAX]);
      end else if (k % 2 == 0) begin
        lvl = 1'b1;
        gap = pick_gap(lim[REG_SPACE_MIN], lim[REG_SPACE_MAX]);
      end else begin
        lvl = 1'b0;
        if (k > 3) b = (one_ok && zero_ok) ? 1'($urandom_range(1)) : one_ok;
        gap = b ? pick_gap(lim[REG_ONE_MIN], lim[REG_ONE_MAX])
                : pick_gap(lim[REG_ZERO_MIN], lim[REG_ZERO_MAX]);
      end
      if (k == bad_at) begin
        if ($urandom_range(1)) lvl = ~lvl;
        else gap = $urandom_range(65535, GLITCH_TICKS);
      end
      edge_gap(lvl, gap, k != 0);
    end
    // a low edge puts a still-listening receiver back to waiting
    if (!shot && $urandom_range(9) != 0) edge_gap(1'b0, $urandom_range(5000, 100), 1'b0);
  endtask

  // short burst of unframed edges, full-range or close-spaced timestamps
  task automatic send_noise();
    int n;
    n = $urandom_range(4, 1);
    repeat (n) begin
      if ($urandom_range(1)) send_edge(1'($urandom_range(1)), $urandom);
      else send_edge(1'($urandom_range(1)), t_now + $urandom_range(40));
    end
  endtask

  // hard stop in case a handshake never completes
  initial begin
    #400000;
    $error("timed out with %0d messages outstanding", pending_cnt);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int          n0;
    int          m0;
    logic [31:0] w_h;
    logic [31:0] w_s;
    logic [31:0] w_o;
    logic [31:0] w_z;
    lim[REG_HEADER_MIN] = 16'd2000;
    lim[REG_HEADER_MAX] = 16'd2800;
    lim[REG_SPACE_MIN]  = 16'd400;
    lim[REG_SPACE_MAX]  = 16'd800;
    lim[REG_ONE_MIN]    = 16'd1000;
    lim[REG_ONE_MAX]    = 16'd1400;
    lim[REG_ZERO_MIN]   = 16'd400;
    lim[REG_ZERO_MAX]   = 16'd800;
    t_now    = '0;
    no_idle  = 1'b0;
    edge_cnt = 0;
    cfg_sets = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed edges against the default windows
    edge_gap(1'b0, 100, 1'b0);   // low edge while waiting
    edge_gap(1'b1, 5, 1'b0);     // glitch
    edge_gap(1'b1, 95, 1'b0);    // edge right after a glitch is dropped
    edge_gap(1'b1, 100, 1'b0);   // opens a header
    edge_gap(1'b0, 2000, 1'b0);  // header exactly on its floor, rejected
    edge_gap(1'b1, 100, 1'b0);
    edge_gap(1'b0, 2800, 1'b0);  // header exactly on its ceiling, rejected
    edge_gap(1'b1, 100, 1'b0);
    edge_gap(1'b0, 2799, 1'b0);  // header just inside
    edge_gap(1'b1, 400, 1'b0);   // space exactly on its floor
    edge_gap(1'b1, 100, 1'b0);
    edge_gap(1'b1, 2500, 1'b0);  // high level where the header should close
    edge_gap(1'b1, 100, 1'b0);
    edge_gap(1'b0, 2001, 1'b0);
    edge_gap(1'b0, 500, 1'b0);   // low level where a space should end
    send_edge(1'b1, '1);         // timer at its top
    edge_gap(1'b0, 2500, 1'b0);  // header across the timer wrap
    edge_gap(1'b1, 799, 1'b0);   // space just under its ceiling
    edge_gap(1'b1, 1200, 1'b0);  // high level where a mark should end
    send_edge(1'b0, '0);         // timer at zero
    edge_gap(1'b1, 100, 1'b0);
    edge_gap(1'b0, 2400, 1'b0);
    edge_gap(1'b1, 600, 1'b0);
    edge_gap(1'b0, 900, 1'b0);   // mark between the zero and one windows

    // framed traffic over several window settings; each setting runs until it has
    // seen enough edges and a handful of messages, with an upper bound on edges
    for (int p = 0; p < 7; p++) begin
      case (p)
        1: program_windows(16'd100, 16'd300, 16'd30, 16'd80, 16'd150, 16'd220, 16'd60, 16'd120);
        // widest possible windows; every mark reads as a one
        2: program_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        // one and zero windows overlap in part
        3: program_windows(16'd2000, 16'd2800, 16'd400, 16'd800, 16'd500, 16'd900, 16'd300,
                           16'd700);
        // inverted zero window, only ones get through
        4: program_windows(16'd2000, 16'd2800, 16'd400, 16'd800, 16'd1000, 16'd1400, 16'd800,
                           16'd400);
        // one window with min equal to max, only shots get through
        5: program_windows(16'd2000, 16'd2800, 16'd400, 16'd800, 16'd1200, 16'd1200, 16'd400,
                           16'd800);
        6: begin
          w_h = rand_window();
          w_s = rand_window();
          w_o = rand_window();
          w_z = rand_window();
          program_windows(w_h[31:16], w_h[15:0], w_s[31:16], w_s[15:0],
                          w_o[31:16], w_o[15:0], w_z[31:16], w_z[15:0]);
        end
        default: ;
      endcase
      no_idle = (p == 3);
      n0 = edge_cnt;
      m0 = predicted_cnt;
      while (edge_cnt - n0 < 120 || (predicted_cnt - m0 < 4 && edge_cnt - n0 < 400)) begin
        if ($urandom_range(99) < 10) send_noise();
        else send_frame();
      end
    end
    no_idle = 1'b0;

    settle(10);
    $display("sent %0d edges over %0d window settings: directed cases, framed traffic, noise",
             edge_cnt, cfg_sets + 1);
    $display("messages predicted %0d, compared %0d", predicted_cnt, checked_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
